[hdl/tpl_pkg.sv]
// Shared types and constants for the text pen layout block.
package tpl_pkg;

  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned GW_W      = 6;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned GAP_RAW_W = 4;
  localparam int unsigned RAW_W     = 12;
  localparam int unsigned MW_W      = 12;
  localparam int unsigned BUD_W     = MW_W + 8;
  localparam int unsigned CFG_D_W   = 12;
  localparam int unsigned OUT_PEN_W = 24;
  localparam int unsigned OUT_ADV_W = 19;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 112;

  localparam int unsigned HALF_PX_Q8 = 128;
  localparam int unsigned UNIT_Q8    = 256;
  localparam int unsigned PIX_MAX    = 65535;

  localparam logic [CODE_W-1:0]    RST_FIRST_CODE = 8'd32;
  localparam logic [CNT_W-1:0]     RST_GLYPH_CNT  = 9'd95;
  localparam logic [GAP_RAW_W-1:0] RST_GAP        = 4'd1;
  localparam logic [RAW_W-1:0]     RST_SCALE      = 12'd256;

  typedef enum logic [2:0] {
    CFG_FIRST_CODE   = 3'd0,
    CFG_GLYPH_COUNT  = 3'd1,
    CFG_GLYPH_GAP    = 3'd2,
    CFG_SCALE_RAW    = 3'd3,
    CFG_DOWNSCALE_OK = 3'd4,
    CFG_MAX_WIDTH    = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CHAR = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              has;
    logic              last;
    logic [CODE_W-1:0] idx;
  } item_ctl_t;

endpackage

[hdl/text_pen_layout_with_ellipsis.sv]
// Top level of the proportional-font text pen layout with ellipsis truncation.
//
//   channel   direction  beat contents
//   s_axis    in         tuser op, tdata code/glyph_width, tlast end of string
//   m_axis    out        tdata per-glyph and summary fields, tlast summary valid
//   cfg       in         cfg_index_i register index, cfg_data_i value
//
// One beat per cycle sustained while m_axis is ready; an s_axis beat passes through
// table read, width multiply, queue, pen accumulate and summary to reach m_axis.
// The front end never stalls; s_axis_tready drops only when front stages plus
// queue hold QDEPTH beats. m_axis stalls back up through the queue.
// Reset clears string state and control; the width table is not cleared.
module text_pen_layout_with_ellipsis import tpl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH  = 256,
  parameter int unsigned PEN_BITS     = 24,
  parameter int unsigned MIN_SCALE_Q8 = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // code[7:0], glyph_width[13:8]
  input  logic                  s_axis_tuser,   // op
  input  logic                  s_axis_tlast,   // last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // glyph_number[7:0], has_glyph[8], pen_q8[32:9], advance_q8[51:33],
  // in_budget[52], total_width[68:53], whole_fits[69], marker_q8[93:70],
  // clipped_width[109:94]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,   // is_final
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [CFG_D_W-1:0]    cfg_data_i
);

  localparam int unsigned SCALE_W =
      ($clog2(MIN_SCALE_Q8) + 8 > RAW_W) ? $clog2(MIN_SCALE_Q8) + 8 : RAW_W;
  localparam int unsigned ADV_W = SCALE_W + 6;
  localparam int unsigned Q_W   = $bits(item_ctl_t) + ADV_W;

  logic [CODE_W-1:0]  first_code;
  logic [CNT_W-1:0]   glyph_count;
  logic [MW_W-1:0]    max_width;
  logic [SCALE_W-1:0] scale;
  logic [SCALE_W+3:0] gap_q8;
  logic [SCALE_W+1:0] scale4;
  logic [BUD_W-1:0]   budget;

  logic               accept;
  logic               push, pop, q_valid;
  item_ctl_t          f_ctl, q_ctl;
  logic [ADV_W-1:0]   f_adv, q_adv;
  logic [Q_W-1:0]     q_out;
  logic [QCNT_W-1:0]  q_cnt;
  logic [1:0]         inflight;

  logic [CODE_W-1:0]    glyph_number;
  logic                 has_glyph, in_budget, is_final, whole_fits;
  logic [OUT_PEN_W-1:0] pen_q8, marker_q8;
  logic [OUT_ADV_W-1:0] advance_q8;
  logic [PIX_W-1:0]     total_width, clipped_width;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (QCNT_W'(inflight) + q_cnt) < QCNT_W'(QDEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;

  tpl_cfg #(
    .MIN_SCALE_Q8 (MIN_SCALE_Q8),
    .SCALE_W      (SCALE_W)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .first_code_o  (first_code),
    .glyph_count_o (glyph_count),
    .max_width_o   (max_width),
    .scale_o       (scale),
    .gap_q8_o      (gap_q8),
    .scale4_o      (scale4),
    .budget_o      (budget)
  );

  tpl_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SCALE_W     (SCALE_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (op_e'(s_axis_tuser)),
    .code_i        (s_axis_tdata[7:0]),
    .glyph_width_i (s_axis_tdata[13:8]),
    .last_i        (s_axis_tlast),
    .first_code_i  (first_code),
    .glyph_count_i (glyph_count),
    .scale_i       (scale),
    .push_o        (push),
    .ctl_o         (f_ctl),
    .adv_o         (f_adv),
    .inflight_o    (inflight)
  );

  tpl_queue #(
    .W (Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_ctl, f_adv}),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_out),
    .count_o (q_cnt)
  );

  assign q_ctl = item_ctl_t'(q_out[Q_W-1:ADV_W]);
  assign q_adv = q_out[ADV_W-1:0];

  tpl_back #(
    .PEN_BITS (PEN_BITS),
    .SCALE_W  (SCALE_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .gap_q8_i        (gap_q8),
    .scale4_i        (scale4),
    .budget_i        (budget),
    .max_width_i     (max_width),
    .q_valid_i       (q_valid),
    .q_ctl_i         (q_ctl),
    .q_adv_i         (q_adv),
    .q_pop_o         (pop),
    .m_ready_i       (m_axis_tready),
    .m_valid_o       (m_axis_tvalid),
    .glyph_number_o  (glyph_number),
    .has_glyph_o     (has_glyph),
    .pen_q8_o        (pen_q8),
    .advance_q8_o    (advance_q8),
    .in_budget_o     (in_budget),
    .is_final_o      (is_final),
    .total_width_o   (total_width),
    .whole_fits_o    (whole_fits),
    .marker_q8_o     (marker_q8),
    .clipped_width_o (clipped_width)
  );

  assign m_axis_tdata = {2'b00, clipped_width, marker_q8, whole_fits, total_width,
                         in_budget, advance_q8, pen_q8, has_glyph, glyph_number};
  assign m_axis_tlast = is_final;

endmodule

[hdl/tpl_cfg.sv]
// Configuration registers and derived scale, gap and budget values.
module tpl_cfg import tpl_pkg::*; #(
  parameter int unsigned MIN_SCALE_Q8 = 32,
  parameter int unsigned SCALE_W      = 13
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [CFG_D_W-1:0]     cfg_data_i,
  output logic [CODE_W-1:0]      first_code_o,
  output logic [CNT_W-1:0]       glyph_count_o,
  output logic [MW_W-1:0]        max_width_o,
  output logic [SCALE_W-1:0]     scale_o,
  output logic [SCALE_W+3:0]     gap_q8_o,
  output logic [SCALE_W+1:0]     scale4_o,
  output logic [BUD_W-1:0]       budget_o
);

  localparam int unsigned GAP_W = SCALE_W + 4;
  localparam int unsigned S4_W  = SCALE_W + 2;
  localparam logic [SCALE_W-1:0] RST_SC = SCALE_W'(UNIT_Q8);

  logic [CODE_W-1:0]    first_code_q;
  logic [CNT_W-1:0]     glyph_count_q;
  logic [GAP_RAW_W-1:0] gap_q;
  logic [RAW_W-1:0]     scale_raw_q;
  logic                 downscale_q;
  logic [MW_W-1:0]      max_width_q;

  logic [SCALE_W-1:0] scale_d, scale_q;
  logic [GAP_W-1:0]   gap_q8_d, gap_q8_q;
  logic [S4_W-1:0]    scale4_d, scale4_q;
  logic [BUD_W-1:0]   budget_d, budget_q;
  logic [BUD_W-1:0]   mw_q8;
  logic [RAW_W-1:0]   minimum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_code_q  <= RST_FIRST_CODE;
      glyph_count_q <= RST_GLYPH_CNT;
      gap_q         <= RST_GAP;
      scale_raw_q   <= RST_SCALE;
      downscale_q   <= 1'b0;
      max_width_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FIRST_CODE:   first_code_q  <= cfg_data_i[CODE_W-1:0];
        CFG_GLYPH_COUNT:  glyph_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_GLYPH_GAP:    gap_q         <= cfg_data_i[GAP_RAW_W-1:0];
        CFG_SCALE_RAW:    scale_raw_q   <= cfg_data_i[RAW_W-1:0];
        CFG_DOWNSCALE_OK: downscale_q   <= cfg_data_i[0];
        CFG_MAX_WIDTH:    max_width_q   <= cfg_data_i[MW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    minimum = downscale_q ? RAW_W'(MIN_SCALE_Q8) : RAW_W'(UNIT_Q8);
    priority if (scale_raw_q != '0 && scale_raw_q < RAW_W'(MIN_SCALE_Q8)) begin
      scale_d = SCALE_W'(scale_raw_q) << 8;
    end else if (scale_raw_q < minimum) begin
      scale_d = SCALE_W'(minimum);
    end else begin
      scale_d = SCALE_W'(scale_raw_q);
    end
    gap_q8_d = GAP_W'(gap_q) * GAP_W'(scale_q);
    scale4_d = {scale_q, 2'b00};
    mw_q8    = {max_width_q, 8'h00};
    budget_d = (mw_q8 > BUD_W'(scale4_q)) ? mw_q8 - BUD_W'(scale4_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= RST_SC;
      gap_q8_q <= GAP_W'(RST_SC);
      scale4_q <= {RST_SC, 2'b00};
      budget_q <= '0;
    end else begin
      scale_q  <= scale_d;
      gap_q8_q <= gap_q8_d;
      scale4_q <= scale4_d;
      budget_q <= budget_d;
    end
  end

  assign first_code_o  = first_code_q;
  assign glyph_count_o = glyph_count_q;
  assign max_width_o   = max_width_q;
  assign scale_o       = scale_q;
  assign gap_q8_o      = gap_q8_q;
  assign scale4_o      = scale4_q;
  assign budget_o      = budget_q;

endmodule

[hdl/tpl_front.sv]
// Front end: classifies bytes, owns the width table, scales the glyph width.
module tpl_front import tpl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned SCALE_W     = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  op_e                   op_i,
  input  logic [CODE_W-1:0]     code_i,
  input  logic [GW_W-1:0]       glyph_width_i,
  input  logic                  last_i,
  input  logic [CODE_W-1:0]     first_code_i,
  input  logic [CNT_W-1:0]      glyph_count_i,
  input  logic [SCALE_W-1:0]    scale_i,
  output logic                  push_o,
  output item_ctl_t             ctl_o,
  output logic [SCALE_W+5:0]    adv_o,
  output logic [1:0]            inflight_o
);

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned ADV_W = SCALE_W + 6;

  logic [GW_W-1:0] mem [TABLE_DEPTH];

  logic [CODE_W-1:0] idx;
  logic              has;
  item_ctl_t         ctl_d;
  logic              wr_en;
  logic              oob;

  logic              v1_q, v2_q;
  item_ctl_t         ctl1_q, ctl2_q;
  logic              oob1_q;
  logic [GW_W-1:0]   rd1_q;
  logic [GW_W-1:0]   w1;
  logic [ADV_W-1:0]  adv2_q;

  always_comb begin
    idx   = code_i - first_code_i;
    has   = (op_i == OP_CHAR) && (code_i >= first_code_i) &&
            ({1'b0, idx} < glyph_count_i);
    ctl_d = '{op: op_i, has: has, last: last_i, idx: has ? idx : '0};
    wr_en = accept_i && (op_i == OP_LOAD) && ({1'b0, code_i} < CNT_W'(TABLE_DEPTH));
    oob   = {1'b0, idx} >= CNT_W'(TABLE_DEPTH);
    w1    = oob1_q ? '0 : rd1_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[code_i[AW-1:0]] <= glyph_width_i;
    end
    rd1_q <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl1_q <= ctl_d;
    oob1_q <= oob;
    ctl2_q <= ctl1_q;
    adv2_q <= ctl1_q.has ? ADV_W'(w1) * ADV_W'(scale_i) : '0;
  end

  assign push_o     = v2_q;
  assign ctl_o      = ctl2_q;
  assign adv_o      = adv2_q;
  assign inflight_o = 2'(v1_q) + 2'(v2_q);

endmodule

[hdl/tpl_queue.sv]
// Short queue between front and back end.
module tpl_queue import tpl_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [W-1:0]      data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [W-1:0]      data_o,
  output logic [QCNT_W-1:0] count_o
);

  localparam int unsigned PW = $clog2(QDEPTH);

  logic [W-1:0]      slots [QDEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (pop_i)  rd_q <= rd_q + PW'(1);
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = slots[rd_q];
  assign count_o = cnt_q;

endmodule

[hdl/tpl_back.sv]
// Back end: pen accumulation, truncation budget, string summary, output register.
module tpl_back import tpl_pkg::*; #(
  parameter int unsigned PEN_BITS = 24,
  parameter int unsigned SCALE_W  = 13
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [SCALE_W+3:0]      gap_q8_i,
  input  logic [SCALE_W+1:0]      scale4_i,
  input  logic [BUD_W-1:0]        budget_i,
  input  logic [MW_W-1:0]         max_width_i,
  input  logic                    q_valid_i,
  input  item_ctl_t               q_ctl_i,
  input  logic [SCALE_W+5:0]      q_adv_i,
  output logic                    q_pop_o,
  input  logic                    m_ready_i,
  output logic                    m_valid_o,
  output logic [CODE_W-1:0]       glyph_number_o,
  output logic                    has_glyph_o,
  output logic [OUT_PEN_W-1:0]    pen_q8_o,
  output logic [OUT_ADV_W-1:0]    advance_q8_o,
  output logic                    in_budget_o,
  output logic                    is_final_o,
  output logic [PIX_W-1:0]        total_width_o,
  output logic                    whole_fits_o,
  output logic [OUT_PEN_W-1:0]    marker_q8_o,
  output logic [PIX_W-1:0]        clipped_width_o
);

  localparam int unsigned ADV_W = SCALE_W + 6;
  localparam int unsigned GAP_W = SCALE_W + 4;
  localparam int unsigned GA_W  = ADV_W + 1;
  localparam int unsigned SUM_W = ((PEN_BITS > ADV_W) ? PEN_BITS : ADV_W) + 2;
  localparam logic [SUM_W-1:0] PEN_MAX = SUM_W'({PEN_BITS{1'b1}});

  function automatic logic [PEN_BITS-1:0] sat_pen(input logic [SUM_W-1:0] v);
    return (v > PEN_MAX) ? {PEN_BITS{1'b1}} : v[PEN_BITS-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] sat_pix(input logic [SUM_W-1:0] v);
    return (v > SUM_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : v[PIX_W-1:0];
  endfunction

  // string state
  logic [PEN_BITS-1:0] pen_q, pen_d, fit_q, fit_d;
  logic                first_q, first_d, trunc_q, trunc_d;

  logic                en_a, en_b;
  logic                is_char, fits;
  logic [GAP_W-1:0]    gap;
  logic [GA_W-1:0]     ga;
  logic [SUM_W-1:0]    fit_sum, pen_g, pen_ga;
  logic [PEN_BITS-1:0] pen_out, pen_upd, fit_upd;
  logic                trunc_upd, first_upd;
  logic [31:0]         adv_ext;

  // stage A
  logic                a_valid_q;
  logic [CODE_W-1:0]   a_glyph_q;
  logic                a_has_q, a_in_q, a_final_q;
  logic [PEN_BITS-1:0] a_pen_q, a_pen_end_q, a_fit_end_q;
  logic [OUT_ADV_W-1:0] a_adv_q;

  // stage B (output register)
  logic                b_valid_q;
  logic [CODE_W-1:0]   b_glyph_q;
  logic                b_has_q, b_in_q, b_final_q, b_whole_q;
  logic [OUT_PEN_W-1:0] b_pen_q, b_marker_q;
  logic [OUT_ADV_W-1:0] b_adv_q;
  logic [PIX_W-1:0]    b_total_q, b_clip_q;

  logic [SUM_W-1:0]    tot_sh, clip_sh;
  logic [PIX_W-1:0]    total, clip_px, clipped;
  logic                whole;
  logic [31:0]         a_pen_ext, a_fit_ext;

  assign en_b    = !b_valid_q || m_ready_i;
  assign en_a    = !a_valid_q || en_b;
  assign q_pop_o = q_valid_i && en_a;

  always_comb begin
    is_char = (q_ctl_i.op == OP_CHAR);
    gap     = first_q ? '0 : gap_q8_i;
    ga      = GA_W'(gap) + GA_W'(q_adv_i);
    fit_sum = SUM_W'(fit_q) + SUM_W'(ga);
    pen_g   = SUM_W'(pen_q) + SUM_W'(gap);
    pen_ga  = SUM_W'(pen_q) + SUM_W'(ga);
    fits    = q_ctl_i.has && !trunc_q && (max_width_i != '0) &&
              (fit_sum <= SUM_W'(budget_i));
    adv_ext = 32'(q_adv_i);

    pen_out   = q_ctl_i.has ? sat_pen(pen_g) : pen_q;
    pen_upd   = pen_q;
    fit_upd   = fit_q;
    trunc_upd = trunc_q;
    first_upd = first_q;
    if (is_char && q_ctl_i.has) begin
      pen_upd   = sat_pen(pen_ga);
      fit_upd   = fits ? sat_pen(fit_sum) : fit_q;
      trunc_upd = trunc_q || !fits;
      first_upd = 1'b0;
    end

    pen_d   = pen_q;
    fit_d   = fit_q;
    trunc_d = trunc_q;
    first_d = first_q;
    if (q_pop_o) begin
      if (is_char && q_ctl_i.last) begin
        pen_d   = '0;
        fit_d   = '0;
        trunc_d = 1'b0;
        first_d = 1'b1;
      end else begin
        pen_d   = pen_upd;
        fit_d   = fit_upd;
        trunc_d = trunc_upd;
        first_d = first_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q     <= '0;
      fit_q     <= '0;
      trunc_q   <= 1'b0;
      first_q   <= 1'b1;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      pen_q   <= pen_d;
      fit_q   <= fit_d;
      trunc_q <= trunc_d;
      first_q <= first_d;
      if (en_a) a_valid_q <= q_pop_o;
      if (en_b) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_glyph_q   <= q_ctl_i.idx;
      a_has_q     <= q_ctl_i.has;
      a_pen_q     <= is_char ? pen_out : '0;
      a_adv_q     <= q_ctl_i.has ? adv_ext[OUT_ADV_W-1:0] : '0;
      a_in_q      <= fits;
      a_final_q   <= is_char && q_ctl_i.last;
      a_pen_end_q <= pen_upd;
      a_fit_end_q <= fit_upd;
    end
  end

  always_comb begin
    a_pen_ext = 32'(a_pen_q);
    a_fit_ext = 32'(a_fit_end_q);
    tot_sh    = (SUM_W'(a_pen_end_q) + SUM_W'(HALF_PX_Q8)) >> 8;
    clip_sh   = (SUM_W'(a_fit_end_q) + SUM_W'(scale4_i) + SUM_W'(HALF_PX_Q8)) >> 8;
    total     = sat_pix(tot_sh);
    clip_px   = sat_pix(clip_sh);
    whole     = (max_width_i != '0) && (total <= PIX_W'(max_width_i));
    priority if (max_width_i == '0) clipped = '0;
    else if (whole)                 clipped = total;
    else                            clipped = clip_px;
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_glyph_q  <= a_glyph_q;
      b_has_q    <= a_has_q;
      b_pen_q    <= a_pen_ext[OUT_PEN_W-1:0];
      b_adv_q    <= a_adv_q;
      b_in_q     <= a_in_q;
      b_final_q  <= a_final_q;
      b_total_q  <= a_final_q ? total : '0;
      b_whole_q  <= a_final_q && whole;
      b_marker_q <= a_final_q ? a_fit_ext[OUT_PEN_W-1:0] : '0;
      b_clip_q   <= a_final_q ? clipped : '0;
    end
  end

  assign m_valid_o       = b_valid_q;
  assign glyph_number_o  = b_glyph_q;
  assign has_glyph_o     = b_has_q;
  assign pen_q8_o        = b_pen_q;
  assign advance_q8_o    = b_adv_q;
  assign in_budget_o     = b_in_q;
  assign is_final_o      = b_final_q;
  assign total_width_o   = b_total_q;
  assign whole_fits_o    = b_whole_q;
  assign marker_q8_o     = b_marker_q;
  assign clipped_width_o = b_clip_q;

endmodule

[hdl/tpl_checker.sv]
// Port-level checks for the text pen layout block, bound to the top level.
module tpl_checker import tpl_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output beat changed while stalled");

  a_summary_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[109:53] == '0))
    else $error("summary fields set on a non-final beat");

  a_no_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[8]) |->
      (m_axis_tdata[7:0] == '0 && m_axis_tdata[52:33] == '0))
    else $error("glyph fields set for a byte without glyph");

  a_fit_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast && m_axis_tdata[69]) |->
      (m_axis_tdata[109:94] == m_axis_tdata[68:53]))
    else $error("clipped width differs from total width on a fitting string");

endmodule

bind text_pen_layout_with_ellipsis tpl_checker u_tpl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[test/text_pen_layout_with_ellipsis_tb.sv]
// Self-checking testbench for the text pen layout block with ellipsis truncation.
`timescale 1ns / 1ps

module text_pen_layout_with_ellipsis_tb import tpl_pkg::*; ;

  localparam longint unsigned PEN_MAX      = (64'd1 << 24) - 1;
  localparam longint unsigned MIN_SCALE_Q8 = 32;
  localparam longint unsigned MARKER_PX    = 4;
  localparam int unsigned     WATCHDOG_MAX = 4000;
  localparam int unsigned     DRAIN_CYCLES = 12;
  localparam int unsigned     MAX_PRINTS   = 100;

  // m_axis tdata, highest field first
  typedef struct packed {
    logic [1:0]           pad;
    logic [PIX_W-1:0]     clipped_width;
    logic [OUT_PEN_W-1:0] marker_q8;
    logic                 whole_fits;
    logic [PIX_W-1:0]     total_width;
    logic                 in_budget;
    logic [OUT_ADV_W-1:0] advance_q8;
    logic [OUT_PEN_W-1:0] pen_q8;
    logic                 has_glyph;
    logic [CODE_W-1:0]    glyph_number;
  } layout_beat_t;

  typedef struct {
    layout_beat_t fields;
    logic         summary;
  } layout_expect_t;

  class pen_layout_scoreboard;
    int unsigned     first_code, glyph_count, glyph_gap, scale_raw, downscale_ok, max_width;
    bit [GW_W-1:0]   glyph_widths [256];
    longint unsigned pen_sum, fit_pen;
    bit              first_pending, truncated;
    layout_expect_t  layout_q[$];
    int unsigned     errors;

    function new();
      first_code   = RST_FIRST_CODE;
      glyph_count  = RST_GLYPH_CNT;
      glyph_gap    = RST_GAP;
      scale_raw    = RST_SCALE;
      downscale_ok = 0;
      max_width    = 0;
      errors       = 0;
      clear_string();
    endfunction

    function void clear_string();
      pen_sum       = 0;
      fit_pen       = 0;
      first_pending = 1'b1;
      truncated     = 1'b0;
    endfunction

    function longint unsigned clamp_pen(longint unsigned v);
      return (v > PEN_MAX) ? PEN_MAX : v;
    endfunction

    function longint unsigned clamp_pix(longint unsigned v);
      return (v > PIX_MAX) ? PIX_MAX : v;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_D_W-1:0] val);
      case (idx)
        CFG_FIRST_CODE:   first_code   = val[CODE_W-1:0];
        CFG_GLYPH_COUNT:  glyph_count  = val[CNT_W-1:0];
        CFG_GLYPH_GAP:    glyph_gap    = val[GAP_RAW_W-1:0];
        CFG_SCALE_RAW:    scale_raw    = val[RAW_W-1:0];
        CFG_DOWNSCALE_OK: downscale_ok = val[0];
        CFG_MAX_WIDTH:    max_width    = val[MW_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(op_e op, logic [CODE_W-1:0] code, logic [GW_W-1:0] gw,
                            logic last);
      layout_expect_t  e;
      longint unsigned sc, lo, idx, gap, adv, bud, total, clipped;
      logic            fits, whole;
      e.fields  = '0;
      e.summary = 1'b0;
      if (op == OP_LOAD) begin
        glyph_widths[code] = gw;
        layout_q.push_back(e);
        return;
      end
      lo = downscale_ok ? MIN_SCALE_Q8 : UNIT_Q8;
      sc = scale_raw;
      if (sc > 0 && sc < MIN_SCALE_Q8) sc = sc * UNIT_Q8;
      else if (sc < lo) sc = lo;
      if (code >= first_code && code - first_code < glyph_count) begin
        idx = code - first_code;
        gap = first_pending ? 0 : glyph_gap * sc;
        adv = glyph_widths[idx] * sc;
        bud = max_width * UNIT_Q8;
        bud = (bud > MARKER_PX * sc) ? bud - MARKER_PX * sc : 0;
        fits = !truncated && max_width != 0 && fit_pen + gap + adv <= bud;
        if (fits) fit_pen = clamp_pen(fit_pen + gap + adv);
        else truncated = 1'b1;
        pen_sum = clamp_pen(pen_sum + gap);
        e.fields.glyph_number = idx[CODE_W-1:0];
        e.fields.has_glyph    = 1'b1;
        e.fields.pen_q8       = pen_sum[OUT_PEN_W-1:0];
        e.fields.advance_q8   = adv[OUT_ADV_W-1:0];
        e.fields.in_budget    = fits;
        pen_sum = clamp_pen(pen_sum + adv);
        first_pending = 1'b0;
      end else begin
        e.fields.pen_q8 = pen_sum[OUT_PEN_W-1:0];
      end
      if (last) begin
        total = clamp_pix((pen_sum + HALF_PX_Q8) >> 8);
        whole = max_width != 0 && total <= max_width;
        if (max_width == 0) clipped = 0;
        else if (whole) clipped = total;
        else clipped = clamp_pix((fit_pen + MARKER_PX * sc + HALF_PX_Q8) >> 8);
        e.summary              = 1'b1;
        e.fields.total_width   = total[PIX_W-1:0];
        e.fields.whole_fits    = whole;
        e.fields.marker_q8     = fit_pen[OUT_PEN_W-1:0];
        e.fields.clipped_width = clipped[PIX_W-1:0];
        clear_string();
      end
      layout_q.push_back(e);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task check_layout(layout_beat_t got, logic got_summary);
      layout_expect_t want;
      if (layout_q.size() == 0) begin
        report("beat with nothing expected", 0, 0);
        return;
      end
      want = layout_q.pop_front();
      if (got.glyph_number !== want.fields.glyph_number)
        report("glyph_number", got.glyph_number, want.fields.glyph_number);
      if (got.has_glyph !== want.fields.has_glyph)
        report("has_glyph", got.has_glyph, want.fields.has_glyph);
      if (got.pen_q8 !== want.fields.pen_q8)
        report("pen_q8", got.pen_q8, want.fields.pen_q8);
      if (got.advance_q8 !== want.fields.advance_q8)
        report("advance_q8", got.advance_q8, want.fields.advance_q8);
      if (got.in_budget !== want.fields.in_budget)
        report("in_budget", got.in_budget, want.fields.in_budget);
      if (got_summary !== want.summary)
        report("is_final", got_summary, want.summary);
      if (got.total_width !== want.fields.total_width)
        report("total_width", got.total_width, want.fields.total_width);
      if (got.whole_fits !== want.fields.whole_fits)
        report("whole_fits", got.whole_fits, want.fields.whole_fits);
      if (got.marker_q8 !== want.fields.marker_q8)
        report("marker_q8", got.marker_q8, want.fields.marker_q8);
      if (got.clipped_width !== want.fields.clipped_width)
        report("clipped_width", got.clipped_width, want.fields.clipped_width);
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [2:0]            cfg_index_i   = '0;
  logic [CFG_D_W-1:0]    cfg_data_i    = '0;

  pen_layout_scoreboard sb;
  int unsigned          tx_idle_pct    = 0;
  int unsigned          rx_stall_pct   = 0;
  int unsigned          stalled_cycles = 0;

  text_pen_layout_with_ellipsis u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_layout(layout_beat_t'(m_axis_tdata), m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        stalled_cycles = 0;
      else
        stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_item(op_e op, logic [CODE_W-1:0] code, logic [GW_W-1:0] gw,
                           logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, gw, code};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, code, gw, last);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CFG_D_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val[CFG_D_W-1:0]);
  endtask

  task automatic set_config(int unsigned fc, int unsigned cnt, int unsigned gap,
                            int unsigned scale, int unsigned ds, int unsigned mw);
    write_reg(CFG_FIRST_CODE, fc);
    write_reg(CFG_GLYPH_COUNT, cnt);
    write_reg(CFG_GLYPH_GAP, gap);
    write_reg(CFG_SCALE_RAW, scale);
    write_reg(CFG_DOWNSCALE_OK, ds);
    write_reg(CFG_MAX_WIDTH, mw);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_config();
    int unsigned scale, mw;
    case ($urandom_range(3))
      0:       scale = $urandom_range(31);
      1:       scale = $urandom_range(255, 32);
      2:       scale = $urandom_range(4095, 256);
      default: scale = ($urandom_range(1) == 0) ? 4095 : 32;
    endcase
    case ($urandom_range(3))
      0:       mw = ($urandom_range(1) == 0) ? 0 : 4095;
      1:       mw = $urandom_range(63, 1);
      2:       mw = $urandom_range(4095, 64);
      default: mw = $urandom_range(400, 1);
    endcase
    set_config($urandom_range(255), $urandom_range(256), $urandom_range(15), scale,
               $urandom_range(1), mw);
  endtask

  // mostly strings of valid glyphs, with stray bytes and table loads mixed in
  task automatic random_strings(int unsigned count);
    int unsigned sent, len, pick;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(48, 20) : $urandom_range(10, 1);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0) begin
          send_item(OP_LOAD, 8'($urandom_range(255)), 6'($urandom_range(63)),
                    1'($urandom_range(1)));
          sent++;
        end
        pick = sb.first_code + $urandom_range(sb.glyph_count == 0 ? 0 : sb.glyph_count - 1);
        if (sb.glyph_count == 0 || pick > 255 || $urandom_range(4) == 0)
          pick = $urandom_range(255);
        send_item(OP_CHAR, pick[CODE_W-1:0], 6'($urandom_range(63)), i == len - 1);
        sent++;
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.layout_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole width table so no unwritten entry is ever read
    for (int i = 0; i < 256; i++)
      send_item(OP_LOAD, 8'(i), (i == 0) ? 6'd0 : (i == 1) ? 6'd63 : 6'($urandom_range(63)),
                1'($urandom_range(1)));

    // reset settings: zero clip width, skipped bytes on both sides of the range
    send_item(OP_LOAD, 8'd255, 6'd63, 1'b1);
    send_item(OP_CHAR, 8'd31, 6'd0, 1'b0);
    send_item(OP_CHAR, 8'd32, 6'd0, 1'b0);
    send_item(OP_CHAR, 8'd126, 6'd0, 1'b0);
    send_item(OP_CHAR, 8'd127, 6'd0, 1'b0);
    send_item(OP_CHAR, 8'd65, 6'd63, 1'b1);
    send_item(OP_CHAR, 8'd0, 6'd0, 1'b1);
    send_item(OP_CHAR, 8'd255, 6'd0, 1'b1);
    drain();

    // full table, widest gap, largest whole multiple: truncation latches early
    set_config(0, 256, 15, 31, 1, 4095);
    send_item(OP_CHAR, 8'd255, 6'd0, 1'b0);
    send_item(OP_CHAR, 8'd255, 6'd0, 1'b0);
    send_item(OP_CHAR, 8'd0, 6'd0, 1'b0);
    send_item(OP_CHAR, 8'd255, 6'd0, 1'b1);
    send_item(OP_CHAR, 8'd0, 6'd0, 1'b1);
    random_strings(75);
    drain();

    for (int p = 2; p < 16; p++) begin
      case (p)
        2:       set_config(32, 95, 0, 0, 0, 1);
        3:       set_config(255, 1, 3, 32, 1, 100);
        4:       set_config(200, 0, 7, 4095, 0, 0);
        5:       set_config(0, 256, 15, 4095, 1, 4095);
        6:       set_config(64, 32, 2, 1, 1, 30);
        default: random_config();
      endcase
      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        default: begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
      endcase
      random_strings(75);
      drain();
    end

    if (sb.layout_q.size() != 0)
      sb.report("beats never returned", sb.layout_q.size(), 0);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
hdl/tpl_pkg.sv
hdl/tpl_cfg.sv
hdl/tpl_front.sv
hdl/tpl_queue.sv
hdl/tpl_back.sv
hdl/text_pen_layout_with_ellipsis.sv
hdl/tpl_checker.sv
test/text_pen_layout_with_ellipsis_tb.sv
